// ===== hw/rtl/ppr_pkg.sv =====
// Package for the pileup/reset rejector: payload structs, controller states,
// register indexes, controller/datapath command and status structs. No deps.
package ppr_pkg;

  localparam int PIXELS_DEF        = 32;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF     = 48;

  localparam logic [23:0] WINDOW_RST    = 24'd1000;
  localparam logic [23:0] RESET_RST     = 24'd1000;
  localparam logic [31:0] THRESHOLD_RST = 32'd4096;
  localparam logic [31:0] GAIN_RST      = 32'd65536;

  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_RESET     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_GAIN      = 2'd3;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic        op;
    logic [47:0] event_time;
    logic [4:0]  pixel;
    logic [15:0] energy;
  } in_beat_t;

  typedef struct packed {
    logic [47:0] out_time;
    logic [4:0]  out_pixel;
    logic [15:0] out_energy;
    logic        last;
    logic        overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_CHECK,
    ST_FULL,
    ST_PUSH,
    ST_FLUSH,
    ST_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat
    logic pop;      // drop oldest entry (emit if kept)
    logic check;    // neighbor compare, charge update
    logic push;     // append captured event
    logic set_ovf;  // sticky overflow
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_flush;
    logic empty;
    logic full;
    logic head_closed; // head gap exceeds window
    logic head_kept;   // head would be emitted
    logic out_busy;    // output register holds an unsent beat
  } status_t;

endpackage

// ===== hw/rtl/ppr_ctrl.sv =====
// Controller FSM for the pileup/reset rejector.
// Depends on ppr_pkg.
module ppr_ctrl
  import ppr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  status_t sts,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // pop may only proceed when a kept head can land in the output register
  logic pop_ok;
  assign pop_ok = !(sts.head_kept && sts.out_busy);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire) state_next = ST_CLOSE;
      ST_CLOSE: begin
        if (sts.is_flush) state_next = ST_FLUSH;
        else if (sts.empty || !sts.head_closed) state_next = ST_CHECK;
      end
      ST_CHECK: state_next = ST_FULL;
      ST_FULL:  if (!sts.full || pop_ok) state_next = ST_PUSH;
      ST_PUSH:  state_next = ST_WAIT;
      ST_FLUSH: if (sts.empty) state_next = ST_WAIT;
      ST_WAIT:  if (!sts.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_fire;
      end
      ST_CLOSE: cmd.pop = !sts.is_flush && !sts.empty && sts.head_closed && pop_ok;
      ST_CHECK: cmd.check = 1'b1;
      ST_FULL: begin
        cmd.set_ovf = sts.full;
        cmd.pop     = sts.full && pop_ok;
      end
      ST_PUSH:  cmd.push = 1'b1;
      ST_FLUSH: cmd.pop = !sts.empty && pop_ok;
      ST_WAIT:  ;
      default:  ;
    endcase
  end

endmodule

// ===== hw/rtl/ppr_dp.sv =====
// Datapath for the pileup/reset rejector: pending FIFO, per-pixel charge and
// reset state, gain multiply, output register. Depends on ppr_pkg.
module ppr_dp
  import ppr_pkg::*;
#(
  parameter int PIXELS        = PIXELS_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_data,
  input  cmd_t      cmd,
  input  logic [23:0] window_ticks,
  input  logic [23:0] reset_ticks,
  input  logic [31:0] reset_threshold,
  input  logic [31:0] gain_q16,
  input  logic      out_stall,
  output status_t   sts,
  output logic      out_valid,
  output out_beat_t out_data
);

  localparam int PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // captured item
  logic                 cur_flush;
  logic [TIME_BITS-1:0] cur_time;
  logic [4:0]           cur_pixel;
  logic [15:0]          cur_energy;
  logic                 cur_rej;
  logic                 ovf;

  // pending FIFO as a shift queue, head at 0
  logic [TIME_BITS-1:0] p_time [PENDING_DEPTH];
  logic [4:0]           p_pixel [PENDING_DEPTH];
  logic [15:0]          p_energy [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] p_rej;
  logic [CW-1:0]        count;

  // per-pixel state
  logic [31:0]          acc [PIXELS];
  logic [TIME_BITS-1:0] reset_end [PIXELS];
  logic [PW-1:0]        idx;

  logic [47:0] prod;
  logic        prod_ok;

  if (PIXELS > 1) begin : g_idx
    assign idx = PW'(cur_pixel % PIXELS);
  end else begin : g_idx1
    assign idx = 1'b0;
  end

  function automatic logic win_in(input logic [TIME_BITS-1:0] t, input logic [TIME_BITS-1:0] p,
                                  input logic [23:0] w);
    logic [TIME_BITS-1:0] g;
    g = (t >= p) ? t - p : '0;
    return (TIME_BITS+24)'(g) <= (TIME_BITS+24)'(w);
  endfunction

  // kept entries, neighbor hits, and the run of entries whose window closes
  logic [PENDING_DEPTH-1:0] kept_vec;
  logic [PENDING_DEPTH-1:0] nb_vec;
  logic [PENDING_DEPTH-1:0] close_vec;
  logic                     later_kept;
  logic                     later_closed_kept;
  logic                     pop_final;
  always_comb begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      kept_vec[i] = (CW'(i) < count) && !p_rej[i];
      nb_vec[i]   = (CW'(i) < count) && p_pixel[i] == cur_pixel &&
                    win_in(cur_time, p_time[i], window_ticks);
    end
    close_vec[0] = (count != '0) && !win_in(cur_time, p_time[0], window_ticks);
    for (int i = 1; i < PENDING_DEPTH; i++)
      close_vec[i] = close_vec[i-1] && (CW'(i) < count) &&
                     !win_in(cur_time, p_time[i], window_ticks);
    later_kept        = |(kept_vec >> 1);
    later_closed_kept = |((kept_vec & close_vec) >> 1);
  end

  // flush: final when no kept entry follows; forced pop is always final;
  // close pop: final when no kept entry follows inside the closing run
  assign pop_final = cur_flush ? !later_kept : (cmd.set_ovf || !later_closed_kept);

  assign sts.is_flush    = cur_flush;
  assign sts.empty       = (count == '0);
  assign sts.full        = (count == CW'(PENDING_DEPTH));
  assign sts.head_closed = !win_in(cur_time, p_time[0], window_ticks);
  assign sts.head_kept   = !p_rej[0];
  assign sts.out_busy    = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_flush  <= in_data.op == OP_FLUSH;
      cur_time   <= TIME_BITS'(in_data.event_time);
      cur_pixel  <= in_data.pixel;
      cur_energy <= in_data.energy;
      prod_ok    <= 1'b0;
    end
    if (cmd.check) begin
      prod    <= 48'(cur_energy) * 48'(gain_q16);
      prod_ok <= 1'b1;
      cur_rej <= (cur_time < reset_end[idx]) || (|nb_vec);
      p_rej   <= p_rej | nb_vec;
    end
    if (cmd.pop) begin
      for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
        p_time[i]   <= p_time[i+1];
        p_pixel[i]  <= p_pixel[i+1];
        p_energy[i] <= p_energy[i+1];
        p_rej[i]    <= p_rej[i+1];
      end
    end
    if (cmd.push) begin
      p_time[count[IW-1:0]]   <= cur_time;
      p_pixel[count[IW-1:0]]  <= cur_pixel;
      p_energy[count[IW-1:0]] <= cur_energy;
      p_rej[count[IW-1:0]]    <= cur_rej;
    end
  end

  // count, accumulators, overflow flag, output register
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [TIME_BITS:0] end_t;
  assign sum     = 33'(acc[idx]) + 33'(prod[47:16]);
  assign sum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign end_t   = {1'b0, cur_time} + (TIME_BITS+1)'(reset_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < PIXELS; i++) begin
        acc[i] <= '0;
        reset_end[i] <= '0;
      end
    end else begin
      if (cmd.set_ovf) ovf <= 1'b1;
      count <= count - CW'(cmd.pop) + CW'(cmd.push);
      if (cmd.push && prod_ok) begin
        if (sum_sat >= reset_threshold) begin
          acc[idx]       <= '0;
          reset_end[idx] <= end_t[TIME_BITS] ? TMAX : end_t[TIME_BITS-1:0];
        end else begin
          acc[idx] <= sum_sat;
        end
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.pop && !p_rej[0]) begin
        out_valid          <= 1'b1;
        out_data.out_time  <= 48'(p_time[0]);
        out_data.out_pixel <= p_pixel[0];
        out_data.out_energy<= p_energy[0];
        out_data.last      <= pop_final;
        out_data.overflow  <= ovf | cmd.set_ovf;
      end
    end
  end

endmodule

// ===== hw/rtl/pixel_pileup_reset_rejector.sv =====
// Top level of the pileup/reset rejector.
// Depends on ppr_pkg, ppr_ctrl, ppr_dp.

// Rejects detector events that pile up on a pixel within the shaping window
// or arrive during a pixel reset; kept events leave in order.
// One item at a time: after an event beat is accepted, the block steps through
// close, check, full test, push and wait before it returns to idle and can
// accept the next beat; close pops each pending entry whose window closes,
// and each kept entry sent waits for the output register to empty; output
// stalls add to this. An end marker steps through close, flush and wait, and
// flush pops every pending entry the same way.
module pixel_pileup_reset_rejector
  import ppr_pkg::*;
#(
  parameter int PIXELS        = PIXELS_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cmd_t cmd;
  status_t sts;
  logic [23:0] window_ticks, reset_ticks;
  logic [31:0] reset_threshold, gain_q16;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RST; reset_ticks <= RESET_RST;
      reset_threshold <= THRESHOLD_RST; gain_q16 <= GAIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WINDOW:    window_ticks <= pwdata[23:0];
        REG_RESET:     reset_ticks <= pwdata[23:0];
        REG_THRESHOLD: reset_threshold <= pwdata;
        REG_GAIN:      gain_q16 <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW:    prdata = {8'd0, window_ticks};
      REG_RESET:     prdata = {8'd0, reset_ticks};
      REG_THRESHOLD: prdata = reset_threshold;
      default:       prdata = gain_q16;
    endcase
  end
  ppr_ctrl u_ctrl (.clk, .rst, .in_fire(in_valid && !in_stall), .sts, .in_stall, .cmd);
  ppr_dp #(.PIXELS(PIXELS), .PENDING_DEPTH(PENDING_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .in_data, .cmd, .window_ticks, .reset_ticks, .reset_threshold,
    .gain_q16, .out_stall, .sts, .out_valid, .out_data);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid || !out_stall) else $error("accept while busy");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_data.overflow && !out_stall) && out_valid |-> out_data.overflow)
    else $error("overflow dropped");
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for pixel_pileup_reset_rejector: directed table plus
// random event streams, checked against an in-bench pileup/reset predictor.
// Depends on ppr_pkg and the RTL of the block.
module tb;
  import ppr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;   // margin for the last item and its pops
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_pileup_reset_rejector dut (.*);

  always #5 clk = ~clk;

  // ---------------- predictor state ----------------
  typedef struct {
    logic [47:0] t;
    logic [4:0]  pix;
    logic [15:0] en;
    bit          rej;
  } pend_entry_t;

  logic [23:0] win_ticks;
  logic [23:0] veto_ticks;
  logic [31:0] thresh;
  logic [31:0] gain;
  pend_entry_t pend_q[$];
  logic [31:0] charge[32];
  logic [47:0] veto_end[32];
  bit          ovf_flag;

  out_beat_t   staged[$];     // results of the item being predicted
  out_beat_t   kept_q[$];     // expected kept events, oldest first

  int errors = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int cycles = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_req = 0;           // bumped by stimulus; receiver honors each bump once

  function automatic logic [63:0] gap(logic [47:0] later, logic [47:0] earlier);
    return (later >= earlier) ? 64'(later - earlier) : 64'd0;
  endfunction

  function automatic void drop_oldest();
    out_beat_t b;
    if (pend_q.size() == 0) return;
    if (!pend_q[0].rej) begin
      b = '0;
      b.out_time = pend_q[0].t;
      b.out_pixel = pend_q[0].pix;
      b.out_energy = pend_q[0].en;
      staged.push_back(b);
    end
    void'(pend_q.pop_front());
  endfunction

  // Works out the kept events released by one accepted beat.
  function automatic void predict_release(in_beat_t it);
    logic [47:0] t;
    int          idx;
    bit          rej;
    logic [63:0] sum;
    logic [63:0] stop;
    pend_entry_t e;
    staged.delete();
    if (it.op == OP_FLUSH) begin
      while (pend_q.size() > 0) drop_oldest();
    end else begin
      t = it.event_time;
      idx = it.pixel;
      // close windows of entries that are far enough in the past
      while (pend_q.size() > 0 && gap(t, pend_q[0].t) > 64'(win_ticks)) drop_oldest();
      rej = t < veto_end[idx];
      // neighbors reject each other, even ones already vetoed by a reset
      foreach (pend_q[i]) begin
        if (pend_q[i].pix == it.pixel && gap(t, pend_q[i].t) <= 64'(win_ticks)) begin
          pend_q[i].rej = 1'b1;
          rej = 1'b1;
        end
      end
      if (pend_q.size() >= 16) begin
        ovf_flag = 1'b1;
        drop_oldest();
      end
      e.t = t;
      e.pix = it.pixel;
      e.en = it.energy;
      e.rej = rej;
      pend_q.push_back(e);
      sum = 64'(charge[idx]) + ((64'(it.energy) * 64'(gain)) >> 16);
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      if (sum >= 64'(thresh)) begin
        sum = 0;
        stop = 64'(t) + 64'(veto_ticks);
        if (stop > 64'(TIME_MAX)) stop = 64'(TIME_MAX);
        veto_end[idx] = stop[47:0];
      end
      charge[idx] = sum[31:0];
    end
    foreach (staged[k]) begin
      staged[k].last = (k == staged.size() - 1);
      staged[k].overflow = ovf_flag;
      kept_q.push_back(staged[k]);
    end
  endfunction

  // ---------------- register port ----------------
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);   // register takes the value at this edge
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WINDOW:    win_ticks = value[23:0];
      REG_RESET:     veto_ticks = value[23:0];
      REG_THRESHOLD: thresh = value;
      REG_GAIN:      gain = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [23:0] w, logic [23:0] r, logic [31:0] th, logic [31:0] g);
    write_reg(REG_WINDOW, {8'd0, w});
    write_reg(REG_RESET, {8'd0, r});
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_GAIN, g);
  endtask

  // ---------------- sender ----------------
  // Offers one beat; valid stays high into the next beat, drain drops it.
  task automatic send_beat(in_beat_t b);
    if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predict_release(b);
    items_sent++;
  endtask

  // Block idle: nothing owed, then room for an item still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (kept_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------- receiver and checker ----------------
  int hold_cnt = 0;
  int hold_ack = 0;
  always @(posedge clk) begin : rx
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %p", $time, out_data);
        errors++;
      end else begin
        want = kept_q.pop_front();
        if (out_data.out_time !== want.out_time || out_data.out_pixel !== want.out_pixel ||
            out_data.out_energy !== want.out_energy || out_data.last !== want.last ||
            out_data.overflow !== want.overflow) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
    // long hold-off lets the pending store fill and back up the input
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rcv_idle > 0) && ($urandom_range(0, 99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  typedef struct {
    in_beat_t  b;
    bit        typed;   // first released beat is known by inspection
    out_beat_t want;
  } row_t;
  row_t rows[$];

  function automatic void add_row(logic op, logic [47:0] t, logic [4:0] p, logic [15:0] e,
                                  bit typed = 0, out_beat_t want = '0);
    row_t r;
    r.b = '{op: op, event_time: t, pixel: p, energy: e};
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  initial begin : stim
    logic [47:0] t;
    in_beat_t    b;
    int          dl;
    int          r;
    win_ticks = WINDOW_RST;
    veto_ticks = RESET_RST;
    thresh = THRESHOLD_RST;
    gain = GAIN_RST;
    foreach (charge[i]) begin
      charge[i] = 0;
      veto_end[i] = 0;
    end
    ovf_flag = 0;

    // defaults after reset: window 1000, reset 1000, threshold 4096, gain 1.0
    add_row(OP_EVENT, 48'd0, 5'd0, 16'd100);
    add_row(OP_EVENT, 48'd5000, 5'd1, 16'd0, 1, '{48'd0, 5'd0, 16'd100, 1'b1, 1'b0});
    add_row(OP_EVENT, 48'd5500, 5'd1, 16'hFFFF);   // pileup, also starts a reset
    add_row(OP_EVENT, 48'd6000, 5'd1, 16'd7);      // inside reset
    add_row(OP_FLUSH, 48'd0, 5'd0, 16'd0);         // all rejected: nothing out
    add_row(OP_EVENT, TIME_MAX, 5'd31, 16'hFFFF);  // reset end saturates
    add_row(OP_FLUSH, TIME_MAX, 5'd31, 16'hFFFF, 1,
            '{TIME_MAX, 5'd31, 16'hFFFF, 1'b1, 1'b0});
    // seventeen events at once overflow the pending store
    for (int p = 0; p < 17; p++) add_row(OP_EVENT, 48'd100000, 5'(p), 16'(p * 3855));
    add_row(OP_FLUSH, 48'hA5A5_A5A5_A5A5, 5'd21, 16'h5A5A);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_beat(rows[i].b);
      if (rows[i].typed && (staged.size() == 0 || staged[0] !== rows[i].want)) begin
        $display("%0t: table row %0d expected %p actual %p", $time, i, rows[i].want,
                 (staged.size() > 0) ? staged[0] : '0);
        errors++;
      end
    end
    drain();

    // random phases, each under its own register setting and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(24'd0, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_regs(24'hFFFFFF, 24'd0, 32'd0, 32'hFFFF_FFFF);
        2: set_regs(24'($urandom_range(50, 2000)), 24'($urandom_range(0, 5000)),
                    $urandom_range(1000, 200000), $urandom());
        default: set_regs(WINDOW_RST, RESET_RST, THRESHOLD_RST, GAIN_RST);
      endcase
      case (ph)
        0: begin snd_idle = 0;  rcv_idle = 0;  end
        1: begin snd_idle = 49; rcv_idle = 0;  end
        2: begin snd_idle = 0;  rcv_idle = 49; end
        default: begin snd_idle = 29; rcv_idle = 29; hold_req++; end
      endcase
      t = (ph == 2) ? {16'($urandom_range(0, 16'hFFFF)), 32'd0} : 48'd200000;
      for (int n = 0; n < 63; n++) begin
        r = $urandom_range(0, 99);
        dl = (win_ticks < 20000) ? 2 * int'(win_ticks) + 2 : 40000000;
        if (r < 5) t = (t > 48'd500) ? t - 48'($urandom_range(0, 500)) : t;
        else if (r < 10) t = t + 48'($urandom());
        else t = t + 48'($urandom_range(0, dl));
        b.op = ($urandom_range(0, 99) < 6) ? OP_FLUSH : OP_EVENT;
        b.event_time = t;
        b.pixel = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 3))
                                               : 5'($urandom_range(0, 31));
        b.energy = 16'($urandom());
        send_beat(b);
      end
      b = '{op: OP_FLUSH, event_time: t, pixel: 5'd0, energy: 16'd0};
      send_beat(b);
      drain();
    end

    $display("Covered %0d beats in: directed extremes, overflow, four register settings",
             items_sent);
    $display("and four idling mixes with one long output hold-off; %0d kept events checked",
             beats_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_ctrl.sv
hw/rtl/ppr_dp.sv
hw/rtl/pixel_pileup_reset_rejector.sv
test/tb.sv
